// ===== sv/lfdc_pkg.sv =====
// shared constants and crc step for the log frame deframer
package lfdc_pkg;

    localparam int unsigned LengthCounterBits = 24;

    localparam logic [31:0] CrcPoly       = 32'hEDB8_8320;
    localparam logic [31:0] CrcOnes       = 32'hFFFF_FFFF;
    localparam logic [31:0] HeaderBytes   = 32'd11;
    localparam logic [20:0] DefaultMinLen = 21'd11;
    localparam logic [23:0] DefaultMaxLen = 24'd1048576;

    localparam int unsigned MinLenBits = 21;
    localparam int unsigned MaxLenBits = 24;
    localparam int unsigned TdataBits  = 128;

    // register indexes on the config port
    localparam logic CfgMinLen = 1'b0;
    localparam logic CfgMaxLen = 1'b1;

    // frame and stream status codes
    localparam logic [2:0] StGood       = 3'd0;
    localparam logic [2:0] StBadLength  = 3'd1;
    localparam logic [2:0] StTruncLen   = 3'd2;
    localparam logic [2:0] StTruncPay   = 3'd3;
    localparam logic [2:0] StTruncCrc   = 3'd4;
    localparam logic [2:0] StCrcMismatch = 3'd5;
    localparam logic [2:0] StCleanEnd   = 3'd6;

    // deframer phases
    localparam logic [1:0] PhLength  = 2'd0;
    localparam logic [1:0] PhPayload = 2'd1;
    localparam logic [1:0] PhCrc     = 2'd2;
    localparam logic [1:0] PhHalt    = 2'd3;

    // result kinds
    localparam logic KindByte   = 1'b0;
    localparam logic KindStatus = 1'b1;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/log_frame_deframer_crc32.sv =====
// log frame deframer: length prefix, payload pass-through, header capture, crc-32 check
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    tdata data byte, tlast end of stream
//  m_axis   out  m_axis_tvalid/m_axis_tready    tdata fields, tuser kind, tlast last byte
//  cfg      in   i_cfg_we                       i_cfg_index, i_cfg_data
//
// one byte per cycle unless stalled; the crc byte step and the length check
// sit between the accepted beat and the output register, so a result is ready
// the cycle after. a beat is taken whenever the output register is empty or
// being drained. synchronous active-low reset returns to the length field of a
// new frame. after an error or a clean end all beats are taken and dropped until reset.
module log_frame_deframer_crc32 #(
    parameter int unsigned LENGTH_COUNTER_BITS = lfdc_pkg::LengthCounterBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config port
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // end_of_stream
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] payload_byte, [10:8] status, [34:11] frame_length, [98:35] timestamp,
    // [114:99] tag_number, [122:115] element_count, [127:123] zero
    output logic [lfdc_pkg::TdataBits-1:0] m_axis_tdata,
    output logic         m_axis_tuser,   // result_kind
    output logic         m_axis_tlast    // last_payload_byte
);

    localparam int unsigned Lcb = LENGTH_COUNTER_BITS;
    localparam logic [32:0] CntMax = (33'd1 << Lcb) - 33'd1;

    logic [lfdc_pkg::MinLenBits-1:0] r_min;
    logic [lfdc_pkg::MaxLenBits-1:0] r_max;

    logic [1:0]     r_phase, n_phase;
    logic [Lcb-1:0] r_pos,   n_pos;
    logic [31:0]    r_len,   n_len;
    logic [31:0]    r_crc,   n_crc;
    logic [31:0]    r_rcrc,  n_rcrc;
    logic [63:0]    r_ts,    n_ts;
    logic [15:0]    r_tag,   n_tag;
    logic [7:0]     r_cnt,   n_cnt;

    logic           r_out_valid;
    logic           r_kind, r_last;
    logic [7:0]     r_byte;
    logic [2:0]     r_status;
    logic [23:0]    r_flen;
    logic [63:0]    r_ots;
    logic [15:0]    r_otag;
    logic [7:0]     r_ocnt;

    logic           acc;
    logic           emit, e_kind, e_last, e_hdr;
    logic [2:0]     e_status;
    logic [23:0]    e_flen;
    logic [63:0]    h_ts;
    logic [15:0]    h_tag;
    logic [7:0]     h_cnt;
    logic           restart;
    logic [31:0]    len_new, rcrc_new;
    logic           len_bad, pay_last;
    logic [7:0]     b;

    function automatic logic [23:0] sat24(input logic [31:0] v);
        return (v[31:24] != 8'd0) ? 24'hFF_FFFF : v[23:0];
    endfunction

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign b = s_axis_tdata;

    assign len_new  = r_len  | ({24'd0, b} << {r_pos[1:0], 3'b000});
    assign rcrc_new = r_rcrc | ({24'd0, b} << {r_pos[1:0], 3'b000});
    assign len_bad  = (len_new < lfdc_pkg::HeaderBytes) || (len_new < {11'd0, r_min})
                   || (len_new > {8'd0, r_max}) || ({1'b0, len_new} > CntMax);
    assign pay_last = ({{(33 - Lcb){1'b0}}, r_pos} + 33'd1) >= {1'b0, r_len};

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_len    = r_len;
        n_crc    = r_crc;
        n_rcrc   = r_rcrc;
        h_ts     = r_ts;
        h_tag    = r_tag;
        h_cnt    = r_cnt;
        restart  = 1'b0;
        emit     = 1'b0;
        e_kind   = lfdc_pkg::KindStatus;
        e_last   = 1'b0;
        e_status = lfdc_pkg::StGood;
        e_flen   = sat24(r_len);
        e_hdr    = 1'b1;
        if (acc && r_phase != lfdc_pkg::PhHalt) begin
            if (s_axis_tlast) begin
                emit    = 1'b1;
                n_phase = lfdc_pkg::PhHalt;
                case (r_phase)
                    lfdc_pkg::PhLength: begin
                        e_status = (r_pos[1:0] == 2'd0) ? lfdc_pkg::StCleanEnd
                                                        : lfdc_pkg::StTruncLen;
                        e_flen   = 24'd0;
                        e_hdr    = 1'b0;
                    end
                    lfdc_pkg::PhPayload: e_status = lfdc_pkg::StTruncPay;
                    default:   e_status = lfdc_pkg::StTruncCrc;
                endcase
            end else begin
                case (r_phase)
                    lfdc_pkg::PhLength: begin
                        n_len = len_new;
                        if (r_pos[1:0] == 2'd3) begin
                            n_pos = '0;
                            if (len_bad) begin
                                emit     = 1'b1;
                                e_status = lfdc_pkg::StBadLength;
                                e_flen   = sat24(len_new);
                                e_hdr    = 1'b0;
                                n_phase  = lfdc_pkg::PhHalt;
                            end else begin
                                n_phase = lfdc_pkg::PhPayload;
                            end
                        end else begin
                            n_pos = r_pos + Lcb'(1);
                        end
                    end
                    lfdc_pkg::PhPayload: begin
                        // header bytes: 0..7 timestamp, 8..9 tag, 10 element count
                        if (r_pos[Lcb-1:3] == '0) begin
                            h_ts = r_ts | ({56'd0, b} << {r_pos[2:0], 3'b000});
                        end else if (r_pos == Lcb'(8)) begin
                            h_tag = {r_tag[15:8], b};
                        end else if (r_pos == Lcb'(9)) begin
                            h_tag = {b, r_tag[7:0]};
                        end else if (r_pos == Lcb'(10)) begin
                            h_cnt = b;
                        end
                        n_crc  = lfdc_pkg::crc_byte(r_crc, b);
                        emit   = 1'b1;
                        e_kind = lfdc_pkg::KindByte;
                        e_last = pay_last;
                        if (pay_last) begin
                            n_phase = lfdc_pkg::PhCrc;
                            n_pos   = '0;
                        end else begin
                            n_pos = r_pos + Lcb'(1);
                        end
                    end
                    default: begin
                        n_rcrc = rcrc_new;
                        if (r_pos[1:0] == 2'd3) begin
                            emit = 1'b1;
                            if ((r_crc ^ lfdc_pkg::CrcOnes) == rcrc_new) begin
                                restart = 1'b1;
                            end else begin
                                e_status = lfdc_pkg::StCrcMismatch;
                                n_phase  = lfdc_pkg::PhHalt;
                            end
                        end else begin
                            n_pos = r_pos + Lcb'(1);
                        end
                    end
                endcase
            end
        end
        n_ts  = h_ts;
        n_tag = h_tag;
        n_cnt = h_cnt;
        if (restart) begin
            n_phase = lfdc_pkg::PhLength;
            n_pos   = '0;
            n_len   = '0;
            n_crc   = lfdc_pkg::CrcOnes;
            n_rcrc  = '0;
            n_ts    = '0;
            n_tag   = '0;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= lfdc_pkg::DefaultMinLen;
            r_max       <= lfdc_pkg::DefaultMaxLen;
            r_phase     <= lfdc_pkg::PhLength;
            r_pos       <= '0;
            r_len       <= '0;
            r_crc       <= lfdc_pkg::CrcOnes;
            r_rcrc      <= '0;
            r_ts        <= '0;
            r_tag       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == lfdc_pkg::CfgMinLen) begin
                    r_min <= i_cfg_data[lfdc_pkg::MinLenBits-1:0];
                end else begin
                    r_max <= i_cfg_data;
                end
            end
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_rcrc  <= n_rcrc;
            r_ts    <= n_ts;
            r_tag   <= n_tag;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind   <= e_kind;
            r_last   <= e_last;
            r_byte   <= (e_kind == lfdc_pkg::KindStatus) ? 8'd0 : b;
            r_status <= e_status;
            r_flen   <= e_flen;
            r_ots    <= e_hdr ? h_ts  : 64'd0;
            r_otag   <= e_hdr ? h_tag : 16'd0;
            r_ocnt   <= e_hdr ? h_cnt : 8'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {5'd0, r_ocnt, r_otag, r_ots, r_flen, r_status, r_byte};

`ifndef SYNTHESIS
    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == lfdc_pkg::PhHalt |=> r_phase == lfdc_pkg::PhHalt)
        else $error("left halt without reset");

    a_short_field_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lfdc_pkg::PhLength || r_phase == lfdc_pkg::PhCrc)
        |-> r_pos[Lcb-1:2] == '0)
        else $error("length or crc field position beyond four bytes");

    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == lfdc_pkg::KindByte)
        |-> m_axis_tdata[10:8] == lfdc_pkg::StGood)
        else $error("payload beat carries a nonzero status");

    a_last_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser == lfdc_pkg::KindByte)
        else $error("last flag on a status beat");

    a_payload_to_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lfdc_pkg::PhPayload && emit && e_last) |=> r_phase == lfdc_pkg::PhCrc)
        else $error("final payload byte did not move to crc field");
`endif

endmodule
